FILE: hdl/grc_pkg.sv
// ----------------------------------------------------------------------------
// grc_pkg
// shared constants and types for the grid ray caster
// ----------------------------------------------------------------------------
package grc_pkg;

  localparam int MAP_DIM   = 512;
  localparam int MAP_AW    = $clog2(MAP_DIM);
  localparam int ADDR_W    = 2 * MAP_AW;
  localparam int COORD_W   = 12;
  localparam int CELL_W    = 9;
  localparam int CFG_W     = 10;
  localparam int CFG_IDX_W = 2;
  localparam int DIST_W    = 23;
  localparam int DELTA_W   = COORD_W + 1;
  localparam int ERR_W     = DELTA_W + 2;
  localparam int CMP_W     = (COORD_W > 12 ? COORD_W : 12) + 1;
  localparam int ACC_W     = 2 * DELTA_W + 1;

  localparam logic signed [7:0] OCC_LIMIT = 8'sd50;
  localparam logic [DIST_W-1:0] DIST_MAX  = {DIST_W{1'b1}};

  localparam logic [CFG_IDX_W-1:0] CFG_MAP_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAP_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_RANGE  = 2'd2;

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_CAST  = 1'b1;

  localparam logic [1:0] OUT_HIT      = 2'd0;
  localparam logic [1:0] OUT_EDGE     = 2'd1;
  localparam logic [1:0] OUT_NOHIT    = 2'd2;
  localparam logic [1:0] OUT_BADSTART = 2'd3;

  typedef struct packed {
    logic mul;
    logic load;
    logic add;
  } dist_ctl_t;

endpackage

FILE: hdl/grc_occ_ram.sv
// ----------------------------------------------------------------------------
// grc_occ_ram
// one-bit occupancy map, one write port and one registered read port
// ----------------------------------------------------------------------------
module grc_occ_ram import grc_pkg::*; (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic              wr_data,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic              rd_data
);

  logic mem [MAP_DIM*MAP_DIM];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

FILE: hdl/grc_dist_unit.sv
// ----------------------------------------------------------------------------
// grc_dist_unit
// shared squarer with accumulator and saturation for the squared distance
// ----------------------------------------------------------------------------
module grc_dist_unit import grc_pkg::*; (
  input  logic               clk,
  input  dist_ctl_t          ctl,
  input  logic [DELTA_W-1:0] operand,
  output logic [DIST_W-1:0]  dist_val
);

  logic [2*DELTA_W-1:0] prod;
  logic [ACC_W-1:0]     acc;

  always_ff @(posedge clk) begin
    if (ctl.mul) begin
      prod <= operand * operand;
    end
    if (ctl.load) begin
      acc <= ACC_W'(prod);
    end else if (ctl.add) begin
      acc <= acc + ACC_W'(prod);
    end
  end

  assign dist_val = (acc > ACC_W'(DIST_MAX)) ? DIST_MAX : acc[DIST_W-1:0];

endmodule

FILE: hdl/grid_ray_cast.sv
// ----------------------------------------------------------------------------
// grid_ray_cast
// occupancy grid with bresenham ray casting
//
// input channel (in_valid/in_stall): cmd selects a map write or a ray cast.
// a write request stores one cell and gives no result.
// a cast request walks the line from start to end, one map cell a cycle
// through the single read port of the map, at most max(dx,dy)+1 cells,
// then squares and sums on the shared squarer in S_SQX, S_SQY and S_SUM
// and loads the output register in S_FIN. the walk ends at the first
// cell past the edge. in_stall stays high for the whole cast; the next
// request can be taken in the cycle after the result is loaded.
// output channel (out_valid/out_stall): a result sits in an output
// register; the next request is taken while it waits, and a further cast
// holds its result until the register is free.
// config channel (cfg_valid/cfg_ready): always ready, index 0 width,
// 1 height, 2 max range; write only while the block is idle.
// reset: config back to 512/512/500, no result pending; the map keeps
// its contents and must be written before it is read.
// ----------------------------------------------------------------------------
module grid_ray_cast import grc_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [CFG_IDX_W-1:0]      cfg_index,
  input  logic [CFG_W-1:0]          cfg_data,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic                      cmd,
  input  logic [CELL_W-1:0]         cell_x,
  input  logic [CELL_W-1:0]         cell_y,
  input  logic signed [7:0]         cell_value,
  input  logic signed [COORD_W-1:0] start_x,
  input  logic signed [COORD_W-1:0] start_y,
  input  logic signed [COORD_W-1:0] end_x,
  input  logic signed [COORD_W-1:0] end_y,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [1:0]                outcome,
  output logic [DIST_W-1:0]         dist_sq,
  output logic signed [COORD_W-1:0] stop_x,
  output logic signed [COORD_W-1:0] stop_y
);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_WALK = 6'b000010,
    S_SQX  = 6'b000100,
    S_SQY  = 6'b001000,
    S_SUM  = 6'b010000,
    S_FIN  = 6'b100000
  } state_t;

  state_t state;

  logic [CFG_W-1:0] map_width;
  logic [CFG_W-1:0] map_height;
  logic [CFG_W-1:0] range_px;

  logic signed [COORD_W-1:0] x0, y0, x1, y1, cx, cy;
  logic [DELTA_W-1:0]        dx, dy, steps;
  logic                      sx_neg, sy_neg, first;
  logic signed [ERR_W-1:0]   err;
  logic [1:0]                res_code;

  logic                in_accept, wr_en, rd_data;
  logic [ADDR_W-1:0]   wr_addr, rd_addr;
  dist_ctl_t           dctl;
  logic [DELTA_W-1:0]  operand;
  logic [DIST_W-1:0]   dist_val;
  logic                out_load;

  // request setup
  logic signed [DELTA_W-1:0] ddx_in, ddy_in;
  logic [DELTA_W-1:0]        dx_in, dy_in, steps_in;
  logic signed [ERR_W-1:0]   err_in;

  // walk step
  logic [CMP_W-1:0]          lim_w, lim_h, cx_ext, cy_ext;
  logic                      in_map, at_end, go_x, go_y;
  logic signed [ERR_W:0]     e2, dx_e, dy_e, err_e;
  logic signed [ERR_W-1:0]   err_step;
  logic signed [COORD_W-1:0] cx_step, cy_step;

  // distance operands
  logic signed [DELTA_W-1:0] dcx, dcy;
  logic [DELTA_W-1:0]        adx, ady;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != S_IDLE);
  assign in_accept = in_valid && !in_stall;

  assign wr_en   = in_accept && (cmd == CMD_WRITE);
  assign wr_addr = {cell_y[MAP_AW-1:0], cell_x[MAP_AW-1:0]};

  always_comb begin
    ddx_in   = {end_x[COORD_W-1], end_x} - {start_x[COORD_W-1], start_x};
    ddy_in   = {end_y[COORD_W-1], end_y} - {start_y[COORD_W-1], start_y};
    dx_in    = ddx_in[DELTA_W-1] ? DELTA_W'(-ddx_in) : DELTA_W'(ddx_in);
    dy_in    = ddy_in[DELTA_W-1] ? DELTA_W'(-ddy_in) : DELTA_W'(ddy_in);
    steps_in = ((dx_in > dy_in) ? dx_in : dy_in) + DELTA_W'(1);
    err_in   = signed'(ERR_W'(dx_in)) - signed'(ERR_W'(dy_in));
  end

  always_comb begin
    lim_w  = (CMP_W'(map_width) > CMP_W'(MAP_DIM)) ? CMP_W'(MAP_DIM) : CMP_W'(map_width);
    lim_h  = (CMP_W'(map_height) > CMP_W'(MAP_DIM)) ? CMP_W'(MAP_DIM) : CMP_W'(map_height);
    cx_ext = {{(CMP_W-COORD_W){1'b0}}, cx};
    cy_ext = {{(CMP_W-COORD_W){1'b0}}, cy};
    in_map = !cx[COORD_W-1] && !cy[COORD_W-1] && (cx_ext < lim_w) && (cy_ext < lim_h);
    at_end = (cx == x1) && (cy == y1);

    e2    = {err, 1'b0};
    dx_e  = signed'((ERR_W+1)'(dx));
    dy_e  = signed'((ERR_W+1)'(dy));
    err_e = {err[ERR_W-1], err};
    go_x  = e2 > -dy_e;
    go_y  = e2 < dx_e;
    err_step = ERR_W'(err_e - (go_x ? dy_e : '0) + (go_y ? dx_e : '0));
    cx_step  = go_x ? (sx_neg ? cx - COORD_W'(1) : cx + COORD_W'(1)) : cx;
    cy_step  = go_y ? (sy_neg ? cy - COORD_W'(1) : cy + COORD_W'(1)) : cy;
  end

  always_comb begin
    if (state == S_IDLE) begin
      rd_addr = {start_y[MAP_AW-1:0], start_x[MAP_AW-1:0]};
    end else begin
      rd_addr = {cy_step[MAP_AW-1:0], cx_step[MAP_AW-1:0]};
    end
  end

  grc_occ_ram u_map (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (cell_value > OCC_LIMIT),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_comb begin
    dcx = {cx[COORD_W-1], cx} - {x0[COORD_W-1], x0};
    dcy = {cy[COORD_W-1], cy} - {y0[COORD_W-1], y0};
    adx = dcx[DELTA_W-1] ? DELTA_W'(-dcx) : DELTA_W'(dcx);
    ady = dcy[DELTA_W-1] ? DELTA_W'(-dcy) : DELTA_W'(dcy);
    if (state == S_SQX) begin
      operand = (res_code == OUT_NOHIT) ? DELTA_W'(range_px) : adx;
    end else begin
      operand = (res_code == OUT_NOHIT) ? '0 : ady;
    end
    dctl.mul  = (state == S_SQX) || (state == S_SQY);
    dctl.load = (state == S_SQY);
    dctl.add  = (state == S_SUM);
  end

  grc_dist_unit u_dist (
    .clk      (clk),
    .ctl      (dctl),
    .operand  (operand),
    .dist_val (dist_val)
  );

  assign out_load = (state == S_FIN) && (!out_valid || !out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      out_valid  <= 1'b0;
      map_width  <= CFG_W'(512);
      map_height <= CFG_W'(512);
      range_px   <= CFG_W'(500);
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          CFG_MAP_WIDTH:  map_width  <= cfg_data;
          CFG_MAP_HEIGHT: map_height <= cfg_data;
          CFG_MAX_RANGE:  range_px   <= cfg_data;
          default: ;
        endcase
      end

      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (in_accept && (cmd == CMD_CAST)) begin
            state <= S_WALK;
          end
        end
        S_WALK: begin
          if ((steps == '0) || !in_map || rd_data || at_end) begin
            state <= S_SQX;
          end
        end
        S_SQX: state <= S_SQY;
        S_SQY: state <= S_SUM;
        S_SUM: state <= S_FIN;
        S_FIN: begin
          if (out_load) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // walk datapath and result register
  always_ff @(posedge clk) begin
    if ((state == S_IDLE) && in_accept && (cmd == CMD_CAST)) begin
      x0       <= start_x;
      y0       <= start_y;
      x1       <= end_x;
      y1       <= end_y;
      cx       <= start_x;
      cy       <= start_y;
      dx       <= dx_in;
      dy       <= dy_in;
      sx_neg   <= !(start_x < end_x);
      sy_neg   <= !(start_y < end_y);
      err      <= err_in;
      steps    <= steps_in;
      first    <= 1'b1;
      res_code <= OUT_NOHIT;
    end else if (state == S_WALK) begin
      priority if (steps == '0) begin
        res_code <= OUT_NOHIT;
      end else if (!in_map) begin
        res_code <= first ? OUT_BADSTART : OUT_EDGE;
      end else if (rd_data) begin
        res_code <= first ? OUT_BADSTART : OUT_HIT;
      end else if (at_end) begin
        res_code <= OUT_NOHIT;
      end else begin
        cx    <= cx_step;
        cy    <= cy_step;
        err   <= err_step;
        steps <= steps - DELTA_W'(1);
        first <= 1'b0;
      end
    end
    if (out_load) begin
      outcome <= res_code;
      dist_sq <= dist_val;
      stop_x  <= cx;
      stop_y  <= cy;
    end
  end

  a_cast_starts_walk: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall && (cmd == CMD_CAST)) |=> (state == S_WALK))
    else $error("cast request did not start a walk");

  a_result_held: assert property (@(posedge clk) disable iff (rst)
    ((state == S_FIN) && out_valid && out_stall) |=> ((state == S_FIN) && out_valid))
    else $error("finished result dropped while output stalled");

  a_badstart_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (outcome == OUT_BADSTART)) |-> (dist_sq == '0))
    else $error("invalid start reported a nonzero distance");

endmodule
